>>> sv/sckf_pkg.sv
`default_nettype none

package sckf_pkg;

  // Ring depth default
  localparam int DEF_RING_DEPTH = 128;

  // Set-1 scan codes with special meaning
  localparam logic [7:0] LSHIFT_DN = 8'h2A;
  localparam logic [7:0] RSHIFT_DN = 8'h36;
  localparam logic [7:0] LSHIFT_UP = 8'hAA;
  localparam logic [7:0] RSHIFT_UP = 8'hB6;
  localparam int         REL_BIT   = 7;
  localparam logic [7:0] MAP_LEN   = 8'd58;

  // Request kinds
  typedef enum logic {
    REQ_SCAN = 1'b0,
    REQ_READ = 1'b1
  } req_kind_t;

  // Control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctl_state_t;

  // Input request
  typedef struct packed {
    logic       req_type;
    logic [7:0] scan_code;
  } req_t;

  // Result
  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       was_empty;
    logic       key_stored;
    logic       key_dropped;
    logic [7:0] fill_level;
  } rsp_t;

  // Ring port enables
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ring_ctl_t;

  // Unshifted key map, codes 0x00..0x39
  localparam logic [7:0] PLAIN_MAP [58] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  // Shifted key map, codes 0x00..0x39
  localparam logic [7:0] UPPER_MAP [58] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h00, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  // Press code to ASCII; 0 outside the map
  function automatic logic [7:0] xlate(input logic [7:0] code, input logic shifted);
    logic [5:0] idx;
    logic [7:0] ch;
    idx = code[5:0];
    ch  = 8'h00;
    if (code < MAP_LEN) begin
      ch = shifted ? UPPER_MAP[idx] : PLAIN_MAP[idx];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> sv/sckf_ring.sv
`default_nettype none

module sckf_ring #(
  parameter int RING_DEPTH = sckf_pkg::DEF_RING_DEPTH,
  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire sckf_pkg::ring_ctl_t ctl,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [7:0]          wr_data,
  input  wire logic [AW-1:0]       rd_addr,
  output logic [7:0]               rd_data
);
  import sckf_pkg::*;

  logic [7:0] mem [RING_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/sckf_ctrl.sv
`default_nettype none

module sckf_ctrl #(
  parameter int RING_DEPTH = sckf_pkg::DEF_RING_DEPTH,
  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int CW = $clog2(RING_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sckf_pkg::req_t       in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sckf_pkg::rsp_t            out_data,
  output sckf_pkg::ring_ctl_t       ring_ctl,
  output logic [AW-1:0]             wr_addr,
  output logic [7:0]                wr_data,
  output logic [AW-1:0]             rd_addr,
  input  wire logic [7:0]           rd_data
);
  import sckf_pkg::*;

  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(RING_DEPTH);

  ctl_state_t    state, state_next;
  logic          shift_down, shift_down_next;
  logic [AW-1:0] write_slot, write_slot_next;
  logic [AW-1:0] read_slot, read_slot_next;
  logic [CW-1:0] held_count, held_count_next;
  logic          out_valid_next;
  rsp_t          out_next;
  logic          acc;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      shift_down <= 1'b0;
      write_slot <= '0;
      read_slot  <= '0;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      shift_down <= shift_down_next;
      write_slot <= write_slot_next;
      read_slot  <= read_slot_next;
      held_count <= held_count_next;
      out_valid  <= out_valid_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    out_data <= out_next;
  end

  // Next state, ring access and result
  always_comb begin
    state_next      = state;
    shift_down_next = shift_down;
    write_slot_next = write_slot;
    read_slot_next  = read_slot;
    held_count_next = held_count;
    out_valid_next  = out_valid && !out_ready;
    out_next        = out_data;
    ring_ctl        = '0;
    wr_addr         = write_slot;
    wr_data         = xlate(in_data.scan_code, shift_down);
    rd_addr         = read_slot;
    in_ready        = (state == ST_IDLE) && (!out_valid || out_ready);
    acc             = in_valid && in_ready;

    case (state)
      ST_IDLE: begin
        if (acc) begin
          out_next = '0;
          if (in_data.req_type == REQ_READ) begin
            if (held_count == '0) begin
              out_next.was_empty  = 1'b1;
              out_next.fill_level = 8'(held_count);
              out_valid_next      = 1'b1;
            end else begin
              // pop: data comes back next cycle
              ring_ctl.rd_en  = 1'b1;
              read_slot_next  = (read_slot == LAST_SLOT) ? '0 : read_slot + 1'b1;
              held_count_next = held_count - 1'b1;
              state_next      = ST_READ;
            end
          end else begin
            out_valid_next      = 1'b1;
            out_next.fill_level = 8'(held_count);
            if (in_data.scan_code inside {LSHIFT_UP, RSHIFT_UP}) begin
              shift_down_next = 1'b0;
            end else if (in_data.scan_code inside {LSHIFT_DN, RSHIFT_DN}) begin
              shift_down_next = 1'b1;
            end else if (!in_data.scan_code[REL_BIT]) begin
              if (held_count == FULL_CNT) begin
                out_next.key_dropped = 1'b1;
              end else begin
                ring_ctl.wr_en      = 1'b1;
                write_slot_next     = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
                held_count_next     = held_count + 1'b1;
                out_next.key_stored = 1'b1;
                out_next.fill_level = 8'(held_count + 1'b1);
              end
            end
          end
        end
      end
      ST_READ: begin
        out_next            = '0;
        out_next.char_valid = 1'b1;
        out_next.char_out   = rd_data;
        out_next.fill_level = 8'(held_count);
        out_valid_next      = 1'b1;
        state_next          = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= FULL_CNT)
    else $error("held count above ring depth");

  a_read_no_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !out_valid && !in_ready)
    else $error("result or request taken during ring read");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> out_valid && out_data.char_valid && state == ST_IDLE)
    else $error("ring read did not produce a character");

  a_store_cnt: assert property (@(posedge clk) disable iff (rst)
    ring_ctl.wr_en |=> held_count == $past(held_count) + 1'b1)
    else $error("store did not bump count");
`endif

endmodule

`default_nettype wire

>>> sv/scan_code_to_ascii_key_fifo.sv
`default_nettype none

// Channel   Signals                          Payload
// in        in_valid / in_ready / in_data    req_type, scan_code
// out       out_valid / out_ready / out_data char_valid .. fill_level
//
// A scan event is answered directly; a read of a non-empty ring passes through
// ST_READ for the registered read port of the memory. One request at a time.
// Synchronous active-high reset clears pointers, count and shift flag; the
// character memory is not cleared. A request is taken while the previous
// result is being taken; a stalled result blocks new requests.

module scan_code_to_ascii_key_fifo #(
  parameter int RING_DEPTH = sckf_pkg::DEF_RING_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sckf_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sckf_pkg::rsp_t      out_data
);
  import sckf_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  ring_ctl_t     ring_ctl;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;

  // Sequencer, pointers and result register
  sckf_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ring_ctl  (ring_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Character memory
  sckf_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .ctl     (ring_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
